/* rtl/cfbc_pkg.sv */
// ----------------------------------------------------------------------------
// Command frame builder package
// Shared types and constants of the command frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package cfbc_pkg;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_PARAM = 1'b1;

    localparam logic [7:0] HDR_FIRST   = 8'hFF;
    localparam logic [7:0] HDR_SECOND  = 8'h55;
    localparam logic [7:0] COUNT_LIMIT = 8'd252;
    localparam logic [7:0] LEN_BASE    = 8'd3;

    localparam int CFBC_QUEUE_DEPTH = 4;

    localparam logic [2:0] STEP_HDR_FIRST  = 3'd0;
    localparam logic [2:0] STEP_HDR_SECOND = 3'd1;
    localparam logic [2:0] STEP_LEN        = 3'd2;
    localparam logic [2:0] STEP_MODE       = 3'd3;
    localparam logic [2:0] STEP_CMD_HIGH   = 3'd4;
    localparam logic [2:0] STEP_CMD_LOW    = 3'd5;
    localparam logic [2:0] STEP_START_CSUM = 3'd6;
    localparam logic [2:0] STEP_PARAM_BYTE = 3'd0;
    localparam logic [2:0] STEP_PARAM_CSUM = 3'd1;

    typedef enum logic {
        JOB_START = 1'b0,
        JOB_PARAM = 1'b1
    } t_job_kind;

    typedef struct packed {
        logic       cmd;
        logic [7:0] mode;
        logic [7:0] command_high;
        logic [7:0] command_low;
        logic [7:0] param_count;
        logic [7:0] param_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_frame;
    } t_out_word;

    typedef struct packed {
        t_job_kind  kind;
        logic [7:0] first_byte;
        logic [7:0] mode;
        logic [7:0] command_high;
        logic [7:0] command_low;
        logic       has_csum;
        logic [7:0] csum;
    } t_job;

endpackage

`default_nettype wire

/* rtl/cfbc_front.sv */
// ----------------------------------------------------------------------------
// Command frame builder front end
// Classifies accepted words, keeps the frame state and queues output jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module cfbc_front
    import cfbc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_in_word i_word,
    output logic          o_push,
    output t_job          o_job
);

    logic [7:0] r_sum, n_sum;
    logic [7:0] r_left, n_left;
    logic       r_open, n_open;

    logic [7:0] count_sat;
    logic [7:0] len_byte;
    logic [7:0] start_sum;
    logic [7:0] param_sum;

    always_comb begin
        count_sat = (i_word.param_count > COUNT_LIMIT) ? COUNT_LIMIT : i_word.param_count;
        len_byte  = LEN_BASE + count_sat;
        start_sum = len_byte + i_word.mode + i_word.command_high + i_word.command_low;
        param_sum = r_sum + i_word.param_byte;

        n_sum  = r_sum;
        n_left = r_left;
        n_open = r_open;
        o_push = 1'b0;

        o_job.kind         = JOB_START;
        o_job.first_byte   = len_byte;
        o_job.mode         = i_word.mode;
        o_job.command_high = i_word.command_high;
        o_job.command_low  = i_word.command_low;
        o_job.has_csum     = 1'b0;
        o_job.csum         = 8'd0 - start_sum;

        if (i_accept) begin
            if (i_word.cmd == CMD_START) begin
                o_push = 1'b1;
                if (count_sat == 8'd0) begin
                    o_job.has_csum = 1'b1;
                    n_sum  = 8'd0;
                    n_left = 8'd0;
                    n_open = 1'b0;
                end else begin
                    n_sum  = start_sum;
                    n_left = count_sat;
                    n_open = 1'b1;
                end
            end else if (r_open && (r_left != 8'd0)) begin
                o_push           = 1'b1;
                o_job.kind       = JOB_PARAM;
                o_job.first_byte = i_word.param_byte;
                o_job.csum       = 8'd0 - param_sum;
                n_left           = r_left - 8'd1;
                if (r_left == 8'd1) begin
                    o_job.has_csum = 1'b1;
                    n_sum  = 8'd0;
                    n_open = 1'b0;
                end else begin
                    n_sum = param_sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= 8'd0;
            r_left <= 8'd0;
            r_open <= 1'b0;
        end else begin
            r_sum  <= n_sum;
            r_left <= n_left;
            r_open <= n_open;
        end
    end

endmodule

`default_nettype wire

/* rtl/cfbc_queue.sv */
// ----------------------------------------------------------------------------
// Command frame builder job queue
// Show-ahead queue of jobs between the front end and the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module cfbc_queue
    import cfbc_pkg::*;
#(
    parameter int DEPTH = CFBC_QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output t_job      o_head,
    output logic      o_full,
    output logic      o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push;
    logic          do_pop;

    always_comb begin
        o_full   = (r_count == CW'(DEPTH));
        o_empty  = (r_count == '0);
        do_push  = i_push && !o_full;
        do_pop   = i_pop && !o_empty;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
        o_head = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

/* rtl/cfbc_back.sv */
// ----------------------------------------------------------------------------
// Command frame builder serializer
// Turns queued jobs into frame bytes in an output register, one word per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module cfbc_back
    import cfbc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_job i_head,
    input  wire logic i_empty,
    output logic      o_pop,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out_word o_out_data
);

    logic [2:0] r_step, n_step;
    logic       r_out_valid;
    t_out_word  r_out_data;
    logic       load;
    logic       emit;
    logic [2:0] last_step;
    t_out_word  word;

    always_comb begin
        load = !r_out_valid || i_out_ready;
        emit = load && !i_empty;

        unique case (i_head.kind)
            JOB_START: last_step = i_head.has_csum ? STEP_START_CSUM : STEP_CMD_LOW;
            JOB_PARAM: last_step = i_head.has_csum ? STEP_PARAM_CSUM : STEP_PARAM_BYTE;
            default:   last_step = STEP_PARAM_BYTE;
        endcase

        word.last_of_frame = 1'b0;
        word.out_byte      = i_head.csum;
        if (i_head.kind == JOB_START) begin
            unique case (r_step)
                STEP_HDR_FIRST:  word.out_byte = HDR_FIRST;
                STEP_HDR_SECOND: word.out_byte = HDR_SECOND;
                STEP_LEN:        word.out_byte = i_head.first_byte;
                STEP_MODE:       word.out_byte = i_head.mode;
                STEP_CMD_HIGH:   word.out_byte = i_head.command_high;
                STEP_CMD_LOW:    word.out_byte = i_head.command_low;
                default: begin
                    word.out_byte      = i_head.csum;
                    word.last_of_frame = 1'b1;
                end
            endcase
        end else begin
            if (r_step == STEP_PARAM_BYTE) begin
                word.out_byte = i_head.first_byte;
            end else begin
                word.out_byte      = i_head.csum;
                word.last_of_frame = 1'b1;
            end
        end

        o_pop  = emit && (r_step == last_step);
        n_step = r_step;
        if (emit) begin
            n_step = o_pop ? 3'd0 : r_step + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (load) begin
                r_out_valid <= !i_empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

/* rtl/command_frame_builder_checksum.sv */
// ----------------------------------------------------------------------------
// Command frame builder with checksum
// Top level: front end, job queue and byte serializer.
// ----------------------------------------------------------------------------
// A start word produces the header 0xFF 0x55, the length byte, the mode and
// both command bytes, plus the checksum when the count is zero; each
// parameter word of an open frame produces its byte, plus the checksum after
// the last one. The input takes one word per cycle while the job queue of
// QUEUE_DEPTH entries has room; the output gives one word per cycle from the
// serializer while it is not stalled, so a start word gives six or seven
// bytes and a parameter word one or two, and the output byte rate sets the
// sustained input rate. Each output word is registered in the serializer
// once its job is at the head of the queue.
`default_nettype none

module command_frame_builder_checksum
    import cfbc_pkg::*;
#(
    parameter int QUEUE_DEPTH = CFBC_QUEUE_DEPTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_word i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_word     o_out_data
);

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_job job;
    t_job head;

    assign o_in_ready = !q_full;

    cfbc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (i_in_valid && o_in_ready),
        .i_word   (i_in_data),
        .o_push   (push),
        .o_job    (job)
    );

    cfbc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    cfbc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

/* rtl/cfbc_checker.sv */
// ----------------------------------------------------------------------------
// Command frame builder checker
// Port-level checks on the command frame builder, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module cfbc_checker
    import cfbc_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire t_in_word  i_in_data,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_word o_out_data
);

    a_in_word_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("stalled input word withdrawn or changed");

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output word withdrawn before it was taken");

    a_out_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("stalled output word changed");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_reset_frees_queue: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready after reset");

endmodule

bind command_frame_builder_checksum cfbc_checker u_cfbc_checker (.*);

`default_nettype wire
